/* rtl/rcsc_pkg.sv */
// Shared types and constants for the radio config session controller.
// No dependencies.
`default_nettype none
package rcsc_pkg;
  localparam logic [1:0] FUNC_SEND    = 2'd0;
  localparam logic [1:0] FUNC_SUCCESS = 2'd1;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd2;
  localparam logic [1:0] FUNC_RX      = 2'd3;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_BEACON = 2'd1;
  localparam logic [1:0] KIND_RESP   = 2'd2;
  localparam logic [1:0] KIND_INFO   = 2'd3;

  localparam logic [3:0] ST_NONE      = 4'd0;
  localparam logic [3:0] ST_CONNECTED = 4'd1;
  localparam logic [3:0] ST_DISCONN   = 4'd2;
  localparam logic [3:0] ST_TIMEOUT   = 4'd3;
  localparam logic [3:0] ST_BAD_LEN   = 4'd4;
  localparam logic [3:0] ST_UUID      = 4'd5;
  localparam logic [3:0] ST_PASS      = 4'd6;
  localparam logic [3:0] ST_SEED      = 4'd7;
  localparam logic [3:0] ST_UNHANDLED = 4'd8;

  localparam logic [7:0]  CMD_CONNECT    = 8'h31;
  localparam logic [7:0]  CMD_DISCONNECT = 8'h64;
  localparam logic [5:0]  LEN_CONNECT    = 6'd18;
  localparam logic [5:0]  LEN_DISCONNECT = 6'd1;
  localparam logic [6:0]  CH_CONFIG      = 7'd79;
  localparam logic [6:0]  CH_MAX         = 7'd69;
  localparam logic [6:0]  LFSR_TAPS      = 7'h60;
  localparam logic [39:0] BEACON_ADDR    = 40'h7863724C42;

  localparam logic [0:0] REG_UUID = 1'd0;
  localparam logic [0:0] REG_PASS = 1'd1;

  // start request from the controller to the hop builder
  typedef struct packed {
    logic       start;
    logic [7:0] offset;
    logic [6:0] seed;
  } hop_cmd_t;
endpackage
`default_nettype wire

/* rtl/rcsc_ram.sv */
// Generic two-port RAM with registered read.
// No dependencies.
`default_nettype none
module rcsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/rcsc_hop_gen.sv */
// Hop channel builder: per candidate an LFSR step, a mod-127 reduction,
// then a scan of the filled entries. Depends on rcsc_pkg and rcsc_ram.
`default_nettype none
module rcsc_hop_gen #(
  parameter int HOP_COUNT = 20
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire rcsc_pkg::hop_cmd_t           cmd,
  output logic                              busy,
  input  wire logic [$clog2(HOP_COUNT+1)-1:0] rd_pos,
  output logic      [6:0]                   rd_chan
);
  import rcsc_pkg::*;
  localparam int AW = (HOP_COUNT > 1) ? $clog2(HOP_COUNT) : 1;
  localparam int CW = $clog2(HOP_COUNT + 1);
  localparam int SW = $clog2(127 * HOP_COUNT + 1);
  localparam logic [SW-1:0] STEP_LIMIT = SW'(127 * HOP_COUNT);
  localparam logic [CW-1:0] FILL_MAX = CW'(HOP_COUNT);

  typedef enum logic [2:0] {S_IDLE, S_STEP, S_MOD, S_SCAN, S_CMP} state_t;
  state_t state_r;

  logic [6:0]    lfsr_r, cand_r;
  logic [7:0]    offset_r;
  logic [8:0]    sum_r;
  logic [CW-1:0] filled_r, scan_r;
  logic [SW-1:0] steps_r;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [6:0]    rdata;
  logic [6:0]    lfsr_nxt;

  assign busy = (state_r != S_IDLE);
  assign rd_chan = rdata;
  assign lfsr_nxt = lfsr_r[0] ? ((lfsr_r >> 1) ^ LFSR_TAPS) : (lfsr_r >> 1);
  assign we = (state_r == S_SCAN) && (scan_r == filled_r);
  assign waddr = filled_r[AW-1:0];
  assign raddr = busy ? scan_r[AW-1:0] : rd_pos[AW-1:0];

  rcsc_ram #(.WIDTH(7), .DEPTH(HOP_COUNT)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(cand_r),
    .raddr(raddr), .rdata(rdata)
  );

  // sequencer: step, reduce mod 127, scan table for duplicates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cmd.start) begin
            lfsr_r   <= cmd.seed;
            offset_r <= cmd.offset;
            filled_r <= '0;
            steps_r  <= '0;
            state_r  <= S_STEP;
          end
        end
        S_STEP: begin
          if (filled_r == FILL_MAX || steps_r == STEP_LIMIT) begin
            state_r <= S_IDLE;
          end else begin
            lfsr_r  <= lfsr_nxt;
            sum_r   <= {2'b0, lfsr_nxt} + {1'b0, offset_r};
            steps_r <= steps_r + 1'b1;
            state_r <= S_MOD;
          end
        end
        S_MOD: begin
          // sum <= 382, subtract 0 to 3 times 127 picked by compare
          if (sum_r >= 9'd381) begin
            cand_r <= 7'(sum_r - 9'd381);
          end else if (sum_r >= 9'd254) begin
            cand_r <= 7'(sum_r - 9'd254);
          end else if (sum_r >= 9'd127) begin
            cand_r <= 7'(sum_r - 9'd127);
          end else begin
            cand_r <= sum_r[6:0];
          end
          scan_r  <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (cand_r > CH_MAX) begin
            state_r <= S_STEP;
          end else if (scan_r == filled_r) begin
            filled_r <= filled_r + 1'b1;
            state_r  <= S_STEP;
          end else begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (rdata == cand_r) begin
            state_r <= S_STEP;
          end else begin
            scan_r  <= scan_r + 1'b1;
            state_r <= S_SCAN;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/radio_config_session_controller.sv */
// Top level: APB registers, session state, event sequencer.
// Depends on rcsc_pkg, rcsc_hop_gen, rcsc_ram.
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/in_stall | func, now_ms, slots, rx fields
//  out_    | output    | out_valid/out_stall | kind, channel, address, status
//  cfg_    | input     | APB psel/penable | uuid at 0x0, pass code at 0x8
//
// A request passes through S_EXEC to S_OUT, with S_READ between them for a send
// while connected (hop RAM read). in_stall stays high until the result is taken.
// A connect runs the hop builder and out_valid stays low until it finishes; each
// candidate takes an LFSR step, a mod-127 reduction and a scan of the filled
// entries. Synchronous active-low reset.
`default_nettype none
module radio_config_session_controller #(
  parameter int HOP_COUNT = 20,
  parameter int LINK_TIMEOUT_MS = 600
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [31:0] in_now_ms,
  input  wire logic [7:0]  in_hop_slot,
  input  wire logic [7:0]  in_transmission_slot,
  input  wire logic [7:0]  in_rx_command,
  input  wire logic [5:0]  in_rx_length,
  input  wire logic [63:0] in_rx_identity,
  input  wire logic [39:0] in_rx_address,
  input  wire logic [15:0] in_rx_pass,
  input  wire logic [7:0]  in_rx_hop_offset,
  input  wire logic [7:0]  in_rx_hop_seed,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_packet_kind,
  output logic [6:0]       out_radio_channel,
  output logic [39:0]      out_radio_address,
  output logic             out_link_up,
  output logic [3:0]       out_status,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  import rcsc_pkg::*;
  localparam int CW = $clog2(HOP_COUNT + 1);
  localparam logic [CW-1:0] POS_LAST = CW'(HOP_COUNT - 1);
  localparam logic [31:0] TIMEOUT = 32'(LINK_TIMEOUT_MS);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_READ, S_OUT} state_t;
  state_t state_r;

  logic [63:0] uuid_r;
  logic [15:0] pass_r;
  logic        open_r;
  logic [31:0] last_r;
  logic [39:0] saddr_r;
  logic [CW-1:0] pos_r;

  logic [1:0]  func_r, kind_r;
  logic [31:0] now_r;
  logic [7:0]  hslot_r, tslot_r, cmd_r, hoff_r, seed_r;
  logic [5:0]  len_r;
  logic [63:0] ident_r;
  logic [39:0] raddr_in_r;
  logic [15:0] rpass_r;
  logic [6:0]  chan_r;
  logic [39:0] oaddr_r;
  logic [3:0]  status_r;
  logic        wait_hop_r;

  hop_cmd_t hcmd;
  logic     hop_busy;
  logic [6:0] hop_chan;
  logic     wr, accept;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign prdata = (paddr[3] == REG_PASS) ? {48'b0, pass_r} : uuid_r;
  assign in_stall = (state_r != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_valid = (state_r == S_OUT) && !wait_hop_r;
  assign out_packet_kind = kind_r;
  assign out_radio_channel = chan_r;
  assign out_radio_address = oaddr_r;
  assign out_link_up = open_r;
  assign out_status = status_r;

  rcsc_hop_gen #(.HOP_COUNT(HOP_COUNT)) u_hop (
    .clk(clk), .rst_n(rst_n), .cmd(hcmd), .busy(hop_busy),
    .rd_pos(pos_r), .rd_chan(hop_chan)
  );

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uuid_r <= '0;
      pass_r <= '0;
    end else if (wr && paddr[2:0] == 3'd0) begin
      if (paddr[3] == REG_UUID) uuid_r <= pwdata;
      else pass_r <= pwdata[15:0];
    end
  end

  // event decode: start the hop builder on a valid connect
  always_comb begin
    hcmd.start  = 1'b0;
    hcmd.offset = hoff_r;
    hcmd.seed   = seed_r[6:0];
    if (state_r == S_EXEC && func_r == FUNC_RX && !open_r && cmd_r == CMD_CONNECT &&
        len_r == LEN_CONNECT && ident_r == uuid_r && rpass_r == pass_r &&
        seed_r != 8'd0 && !seed_r[7]) begin
      hcmd.start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      open_r     <= 1'b0;
      last_r     <= '0;
      saddr_r    <= '0;
      pos_r      <= '0;
      wait_hop_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            func_r <= in_func;  now_r <= in_now_ms;
            hslot_r <= in_hop_slot;  tslot_r <= in_transmission_slot;
            cmd_r <= in_rx_command;  len_r <= in_rx_length;
            ident_r <= in_rx_identity;  raddr_in_r <= in_rx_address;
            rpass_r <= in_rx_pass;  hoff_r <= in_rx_hop_offset;
            seed_r <= in_rx_hop_seed;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          kind_r <= KIND_NONE;  chan_r <= '0;  oaddr_r <= '0;
          status_r <= ST_NONE;
          state_r <= S_OUT;
          unique case (func_r)
            FUNC_SEND: begin
              if (open_r) begin
                kind_r  <= KIND_INFO;
                oaddr_r <= saddr_r;
                state_r <= S_READ;
              end else if (hslot_r == 8'd0) begin
                chan_r <= CH_CONFIG;
                if (tslot_r == 8'd1) begin
                  kind_r <= KIND_BEACON;  oaddr_r <= BEACON_ADDR;
                end else begin
                  kind_r <= KIND_RESP;  oaddr_r <= uuid_r[39:0];
                end
              end
            end
            FUNC_SUCCESS: last_r <= now_r;
            FUNC_TIMEOUT: begin
              if (open_r && (now_r - last_r) > TIMEOUT) begin
                open_r <= 1'b0;  status_r <= ST_TIMEOUT;
              end
            end
            default: begin
              if (!open_r) begin
                if (cmd_r != CMD_CONNECT) status_r <= ST_UNHANDLED;
                else if (len_r != LEN_CONNECT) status_r <= ST_BAD_LEN;
                else if (ident_r != uuid_r) status_r <= ST_UUID;
                else if (rpass_r != pass_r) status_r <= ST_PASS;
                else if (seed_r == 8'd0 || seed_r[7]) status_r <= ST_SEED;
                else begin
                  saddr_r <= raddr_in_r;  pos_r <= '0;  open_r <= 1'b1;
                  status_r <= ST_CONNECTED;  wait_hop_r <= 1'b1;
                end
              end else begin
                if (cmd_r != CMD_DISCONNECT) status_r <= ST_UNHANDLED;
                else if (len_r != LEN_DISCONNECT) status_r <= ST_BAD_LEN;
                else begin
                  open_r <= 1'b0;  status_r <= ST_DISCONN;
                end
              end
            end
          endcase
        end
        S_READ: begin
          // hop RAM read data is ready this cycle
          chan_r  <= hop_chan;
          pos_r   <= (pos_r == POS_LAST) ? '0 : pos_r + 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (wait_hop_r) begin
            if (!hop_busy && !hcmd.start) wait_hop_r <= 1'b0;
          end else if (!out_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/rcsc_checker.sv */
// Port-level checker for the session controller, bound to the top level.
// Depends on rcsc_pkg.
`default_nettype none
module rcsc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_packet_kind,
  input wire logic [6:0]  out_radio_channel,
  input wire logic        out_link_up,
  input wire logic [3:0]  out_status
);
  import rcsc_pkg::*;

  // a stalled request stays offered
  a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid) else $error("request dropped under stall");

  // a request in flight blocks further input
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open while result pending");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("result changed under stall");

  // connect success always reports link up
  a_conn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_CONNECTED |-> out_link_up)
    else $error("connected without link");

  // beacon and response go on the config channel while the link is down
  a_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_packet_kind == KIND_BEACON || out_packet_kind == KIND_RESP)
    |-> out_radio_channel == CH_CONFIG && !out_link_up)
    else $error("config packet on wrong channel");
endmodule

bind radio_config_session_controller rcsc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_packet_kind(out_packet_kind), .out_radio_channel(out_radio_channel),
  .out_link_up(out_link_up), .out_status(out_status)
);
`default_nettype wire
